// ----- src/imu_channel_calibrate_lowpass_top_defines.svh -----
// Assertion macros shared by the IMU calibrate and low-pass RTL.
`ifndef IMU_CHANNEL_CALIBRATE_LOWPASS_TOP_DEFINES_SVH
`define IMU_CHANNEL_CALIBRATE_LOWPASS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define IMU_CAL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imu_cal: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define IMU_CAL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("imu_cal: next-cycle check failed");

`endif

// ----- src/imu_cal_pkg.sv -----
// Shared types and constants for the IMU calibrate and low-pass block.
`timescale 1ns / 1ps

package imu_cal_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int STATE_WIDTH_DEF  = 32;

   localparam int NUM_CHAN   = 9;
   localparam int CHAN_W     = 4;
   localparam int AXES       = 3;
   localparam int FIELD_W    = 16;
   localparam int REG_W      = 48;
   localparam int SIGNS_W    = 9;
   localparam int ONE_Q16    = 1 << FIELD_W;
   localparam int ROUND_HALF = ONE_Q16 / 2;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [1:0] KIND_GYRO  = 2'd0;
   localparam logic [1:0] KIND_ACCEL = 2'd1;
   localparam logic [1:0] KIND_MAG   = 2'd2;
   localparam logic [1:0] CODE_NONE  = 2'd3;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [2:0] {
      REG_GYRO_BIAS,
      REG_ACCEL_BIAS,
      REG_MAG_BIAS,
      REG_GYRO_SCALE,
      REG_ACCEL_SCALE,
      REG_MAG_SCALE,
      REG_AXIS_SIGNS,
      REG_LPF_ALPHAS
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAL,
      ST_DIFF,
      ST_LO,
      ST_HI,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic calc_x;
      logic calc_d;
      logic calc_lo;
      logic calc_hi;
      logic commit;
   } ctrl_type;

   typedef struct packed {
      logic [2:0][REG_W-1:0] bias;
      logic [2:0][REG_W-1:0] scale;
      logic [SIGNS_W-1:0]    axis_signs;
      logic [REG_W-1:0]      lpf_alphas;
   } cfg_type;

endpackage

// ----- src/imu_cal_csr.sv -----
// APB-style configuration registers for the IMU calibrate and low-pass block.
`timescale 1ns / 1ps

module imu_cal_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [imu_cal_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [imu_cal_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [imu_cal_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready,
   output imu_cal_pkg::cfg_type               cfg
);
   import imu_cal_pkg::*;

   logic [2:0][REG_W-1:0] bias_ff;
   logic [2:0][REG_W-1:0] scale_ff;
   logic [SIGNS_W-1:0]    signs_ff;
   logic [REG_W-1:0]      alphas_ff;
   reg_index_type         reg_idx;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff   <= '0;
         scale_ff  <= '0;
         signs_ff  <= '0;
         alphas_ff <= '1;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_GYRO_BIAS:   bias_ff[0]  <= csr_pwdata[REG_W-1:0];
            REG_ACCEL_BIAS:  bias_ff[1]  <= csr_pwdata[REG_W-1:0];
            REG_MAG_BIAS:    bias_ff[2]  <= csr_pwdata[REG_W-1:0];
            REG_GYRO_SCALE:  scale_ff[0] <= csr_pwdata[REG_W-1:0];
            REG_ACCEL_SCALE: scale_ff[1] <= csr_pwdata[REG_W-1:0];
            REG_MAG_SCALE:   scale_ff[2] <= csr_pwdata[REG_W-1:0];
            REG_AXIS_SIGNS:  signs_ff    <= csr_pwdata[SIGNS_W-1:0];
            REG_LPF_ALPHAS:  alphas_ff   <= csr_pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_GYRO_BIAS:   csr_prdata = CSR_DATA_W'(bias_ff[0]);
         REG_ACCEL_BIAS:  csr_prdata = CSR_DATA_W'(bias_ff[1]);
         REG_MAG_BIAS:    csr_prdata = CSR_DATA_W'(bias_ff[2]);
         REG_GYRO_SCALE:  csr_prdata = CSR_DATA_W'(scale_ff[0]);
         REG_ACCEL_SCALE: csr_prdata = CSR_DATA_W'(scale_ff[1]);
         REG_MAG_SCALE:   csr_prdata = CSR_DATA_W'(scale_ff[2]);
         REG_AXIS_SIGNS:  csr_prdata = CSR_DATA_W'(signs_ff);
         REG_LPF_ALPHAS:  csr_prdata = CSR_DATA_W'(alphas_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.bias       = bias_ff;
      cfg.scale      = scale_ff;
      cfg.axis_signs = signs_ff;
      cfg.lpf_alphas = alphas_ff;
   end

endmodule

// ----- src/imu_cal_seq.sv -----
// Sequencer that steps one item through the shared multiplier.
`timescale 1ns / 1ps
`include "imu_channel_calibrate_lowpass_top_defines.svh"

module imu_cal_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  out_free,
   output logic                  req_ready,
   output imu_cal_pkg::ctrl_type ctrl
);
   import imu_cal_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CAL;
         end
         ST_CAL:  state_in = ST_DIFF;
         ST_DIFF: state_in = ST_LO;
         ST_LO:   state_in = ST_HI;
         ST_HI:   state_in = ST_DONE;
         ST_DONE: begin
            // hold until the output register can take the item
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         ST_CAL:  ctrl.calc_x  = 1'b1;
         ST_DIFF: ctrl.calc_d  = 1'b1;
         ST_LO:   ctrl.calc_lo = 1'b1;
         ST_HI:   ctrl.calc_hi = 1'b1;
         ST_DONE: ctrl.commit  = out_free;
         default: ;
      endcase
   end

   `IMU_CAL_ASSERT_NXT(a_load_then_cal, clock, reset, ctrl.load, ctrl.calc_x)
   `IMU_CAL_ASSERT_IMP(a_one_step, clock, reset, 1'b1, $onehot0(ctrl))
   `IMU_CAL_ASSERT_NXT(a_busy_after_hi, clock, reset, ctrl.calc_hi, !req_ready)

endmodule

// ----- src/imu_cal_dp.sv -----
// Datapath: sign, bias, shared multiplier, filter state and output register.
`timescale 1ns / 1ps
`include "imu_channel_calibrate_lowpass_top_defines.svh"

module imu_cal_dp #(
   parameter int SAMPLE_WIDTH = imu_cal_pkg::SAMPLE_WIDTH_DEF,
   parameter int STATE_WIDTH  = imu_cal_pkg::STATE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  imu_cal_pkg::ctrl_type         ctrl,
   input  imu_cal_pkg::cfg_type          cfg,
   input  logic [1:0]                    req_kind,
   input  logic [1:0]                    req_axis,
   input  logic signed [SAMPLE_WIDTH-1:0] req_raw_sample,
   output logic                          out_free,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_sensor_out,
   output logic [1:0]                    rsp_axis_out,
   output logic signed [SAMPLE_WIDTH:0]  rsp_oriented_sample,
   output logic signed [STATE_WIDTH-1:0] rsp_filtered_value
);
   import imu_cal_pkg::*;

   localparam int OW   = SAMPLE_WIDTH + 1;
   localparam int DW   = ((OW > FIELD_W + 1) ? OW : FIELD_W + 1) + 1;
   localparam int HW   = STATE_WIDTH + 1 - FIELD_W;
   localparam int MA   = (DW > HW) ? DW : HW;
   localparam int MB   = FIELD_W + 1;
   localparam int MP   = MA + MB;
   localparam int SPW  = STATE_WIDTH + 3;
   localparam int SUMW = STATE_WIDTH + 4;
   localparam int LOW  = 2 * FIELD_W + 1;

   localparam logic signed [STATE_WIDTH-1:0] ST_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
   localparam logic signed [STATE_WIDTH-1:0] ST_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

   function automatic logic [REG_W-1:0] sel_word(input logic [2:0][REG_W-1:0] grp,
                                                 input logic [1:0] k);
      case (k)
         KIND_ACCEL: sel_word = grp[1];
         KIND_MAG:   sel_word = grp[2];
         default:    sel_word = grp[0];
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] field16(input logic [REG_W-1:0] w,
                                                  input logic [1:0] a);
      case (a)
         AXIS_Y:  field16 = w[2*FIELD_W-1:FIELD_W];
         AXIS_Z:  field16 = w[3*FIELD_W-1:2*FIELD_W];
         default: field16 = w[FIELD_W-1:0];
      endcase
   endfunction

   // item registers
   logic [1:0]               kind_ff;
   logic [1:0]               axis_ff;
   logic                     ok_ff;
   logic [CHAN_W-1:0]        ch_ff;
   logic signed [OW-1:0]     oriented_ff;
   logic signed [DW-1:0]     diff_ff;
   logic [FIELD_W-1:0]       scale_ff;
   logic [FIELD_W-1:0]       alpha_ff;
   logic signed [STATE_WIDTH-1:0] x_ff;
   logic signed [STATE_WIDTH:0]   d_ff;
   logic [FIELD_W-1:0]       lo_ff;
   logic signed [SPW-1:0]    step_ff;
   logic signed [STATE_WIDTH-1:0] st_ff [NUM_CHAN];

   // output register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [1:0]               rsp_kind_ff;
   logic [1:0]               rsp_axis_ff;
   logic signed [OW-1:0]     rsp_orient_ff;
   logic signed [STATE_WIDTH-1:0] rsp_filt_ff;

   // load-side logic
   logic                     chan_ok_in;
   logic [CHAN_W-1:0]        ch_calc;
   logic [CHAN_W-1:0]        ch_in;
   logic                     flip;
   logic signed [OW-1:0]     raw_ext;
   logic signed [OW-1:0]     oriented_in;
   logic signed [FIELD_W-1:0] bias;
   logic signed [DW-1:0]     diff_in;

   // shared multiplier
   logic signed [MA-1:0]     mul_a;
   logic signed [MB-1:0]     mul_b;
   logic signed [MP-1:0]     prod;
   logic signed [HW-1:0]     d_hi;
   logic [MP-STATE_WIDTH:0]  x_top;
   logic signed [STATE_WIDTH-1:0] x_in;
   logic signed [STATE_WIDTH-1:0] st_cur;
   logic signed [STATE_WIDTH:0]   d_in;
   logic [LOW-1:0]           lo_sum;
   logic signed [SPW-1:0]    step_in;
   logic signed [SUMW-1:0]   sum;
   logic [SUMW-STATE_WIDTH:0] sum_top;
   logic signed [STATE_WIDTH-1:0] st_new;

   assign chan_ok_in = (req_kind != CODE_NONE) && (req_axis != CODE_NONE);
   assign ch_calc    = CHAN_W'(req_kind) * CHAN_W'(AXES) + CHAN_W'(req_axis);
   assign ch_in      = chan_ok_in ? ch_calc : '0;
   assign flip       = chan_ok_in && cfg.axis_signs[ch_in];
   assign raw_ext    = OW'(req_raw_sample);
   assign oriented_in = flip ? -raw_ext : raw_ext;
   assign bias       = signed'(field16(sel_word(cfg.bias, req_kind), req_axis));
   assign diff_in    = DW'(oriented_in) - DW'(bias);

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         kind_ff     <= req_kind;
         axis_ff     <= req_axis;
         ok_ff       <= chan_ok_in;
         ch_ff       <= ch_in;
         oriented_ff <= oriented_in;
         diff_ff     <= diff_in;
         scale_ff    <= field16(sel_word(cfg.scale, req_kind), req_axis);
         alpha_ff    <= field16(cfg.lpf_alphas, req_kind);
      end
   end

   assign d_hi = d_ff[STATE_WIDTH:FIELD_W];

   // operand select for the one multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (ctrl.calc_x) begin
         mul_a = MA'(diff_ff);
         mul_b = signed'({1'b0, scale_ff});
      end else if (ctrl.calc_lo) begin
         mul_a = MA'({1'b0, d_ff[FIELD_W-1:0]});
         mul_b = signed'({1'b0, alpha_ff});
      end else if (ctrl.calc_hi) begin
         mul_a = MA'(d_hi);
         mul_b = signed'({1'b0, alpha_ff});
      end
   end

   assign prod = mul_a * mul_b;

   // clamp the calibrated value to the state range
   assign x_top = prod[MP-1:STATE_WIDTH-1];
   always_comb begin
      if ((&x_top) || !(|x_top)) begin
         x_in = prod[STATE_WIDTH-1:0];
      end else begin
         x_in = prod[MP-1] ? ST_MIN : ST_MAX;
      end
   end

   assign st_cur  = st_ff[ch_ff];
   assign d_in    = (STATE_WIDTH+1)'(x_ff) - (STATE_WIDTH+1)'(st_cur);
   assign lo_sum  = {1'b0, prod[2*FIELD_W-1:0]} + LOW'(ROUND_HALF);
   assign step_in = SPW'(prod) + SPW'(signed'({1'b0, lo_ff}));

   always_ff @(posedge clock) begin
      if (ctrl.calc_x) x_ff <= x_in;
      if (ctrl.calc_d) d_ff <= d_in;
      if (ctrl.calc_lo) lo_ff <= lo_sum[2*FIELD_W-1:FIELD_W];
      if (ctrl.calc_hi) step_ff <= step_in;
   end

   assign sum     = SUMW'(st_cur) + SUMW'(step_ff);
   assign sum_top = sum[SUMW-1:STATE_WIDTH-1];
   always_comb begin
      if ((&sum_top) || !(|sum_top)) begin
         st_new = sum[STATE_WIDTH-1:0];
      end else begin
         st_new = sum[SUMW-1] ? ST_MIN : ST_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHAN; i++) begin
            st_ff[i] <= '0;
         end
      end else if (ctrl.commit && ok_ff) begin
         st_ff[ch_ff] <= st_new;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         rsp_kind_ff   <= kind_ff;
         rsp_axis_ff   <= axis_ff;
         rsp_orient_ff <= oriented_ff;
         // drop the filter result for an unknown channel
         rsp_filt_ff   <= ok_ff ? st_new : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sensor_out      = rsp_kind_ff;
   assign rsp_axis_out        = rsp_axis_ff;
   assign rsp_oriented_sample = rsp_orient_ff;
   assign rsp_filtered_value  = rsp_filt_ff;

   `IMU_CAL_ASSERT_NXT(a_commit_shows, clock, reset, ctrl.commit, rsp_valid_ff)
   `IMU_CAL_ASSERT_NXT(a_bad_chan_zero, clock, reset, ctrl.commit && !ok_ff, rsp_filt_ff == '0)
   `IMU_CAL_ASSERT_NXT(a_state_matches, clock, reset, ctrl.commit && ok_ff, st_ff[ch_ff] == rsp_filt_ff)

endmodule

// ----- src/imu_channel_calibrate_lowpass_top.sv -----
// Top level of the per-channel IMU calibrate and low-pass filter block.
//
// Usage:
//  - req_* carries one raw sample with its sensor kind and axis; an item is
//    taken when req_valid and req_ready are both high.
//  - rsp_* returns one item per input: the echoed sensor and axis, the sample
//    after the axis sign, and the new Q15.16 filter state of that channel.
//  - csr_* is an APB-style port; register i sits at byte address 8*i.
// Timing:
//  - One shared multiplier is stepped through calibrate, low half and high
//    half of the filter gain product; the item result is registered in the
//    output register at the done step, and rsp_valid rises with it.
//  - req_ready is high only while the sequencer is idle, so a new item is
//    taken only after the last one has been committed.
//  - A result waiting in the output register does not block the next item;
//    the sequencer only stalls at its final step if that register is full.
// Reset clears all nine filter states, loads every low-pass alpha with all
// ones and the remaining configuration registers with zero.
`timescale 1ns / 1ps

module imu_channel_calibrate_lowpass_top #(
   parameter int SAMPLE_WIDTH = imu_cal_pkg::SAMPLE_WIDTH_DEF,
   parameter int STATE_WIDTH  = imu_cal_pkg::STATE_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_kind,
   input  logic [1:0]                         req_axis,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_raw_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_sensor_out,
   output logic [1:0]                         rsp_axis_out,
   output logic signed [SAMPLE_WIDTH:0]       rsp_oriented_sample,
   output logic signed [STATE_WIDTH-1:0]      rsp_filtered_value,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [imu_cal_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [imu_cal_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [imu_cal_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready
);
   import imu_cal_pkg::*;

   cfg_type  cfg;
   ctrl_type ctrl;
   logic     out_free;

   imu_cal_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   imu_cal_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   imu_cal_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .STATE_WIDTH  (STATE_WIDTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .cfg                 (cfg),
      .req_kind            (req_kind),
      .req_axis            (req_axis),
      .req_raw_sample      (req_raw_sample),
      .out_free            (out_free),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_sensor_out      (rsp_sensor_out),
      .rsp_axis_out        (rsp_axis_out),
      .rsp_oriented_sample (rsp_oriented_sample),
      .rsp_filtered_value  (rsp_filtered_value)
   );

endmodule
